### rtl/crccfd_pkg.sv
// Package for the CRC checked frame deframer.
// Holds the phase type, result kinds, frame constants and the CRC byte steps.
// Has no dependencies.
`timescale 1ns / 1ps

package crccfd_pkg;

	localparam logic [7:0]  START_BYTE = 8'hA5;
	localparam logic [7:0]  HCRC_INIT  = 8'hFF;
	localparam logic [15:0] FCRC_INIT  = 16'hFFFF;
	localparam logic [7:0]  HCRC_POLY  = 8'h8C;
	localparam logic [15:0] FCRC_POLY  = 16'h8408;
	localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

	localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
	localparam logic [2:0] KIND_GOOD       = 3'd1;
	localparam logic [2:0] KIND_HCRC_ERR   = 3'd2;
	localparam logic [2:0] KIND_FCRC_ERR   = 3'd3;
	localparam logic [2:0] KIND_LENGTH_ERR = 3'd4;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_COMMAND = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_TRAILER = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] position;
		logic [15:0] length_seen;
		logic [15:0] command_seen;
		logic [7:0]  sequence_seen;
		logic [7:0]  header_crc;
		logic [15:0] frame_crc;
		logic [7:0]  crc_low;
	} parse_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] command_id;
		logic [15:0] payload_offset;
		logic [7:0]  payload_byte;
		logic [15:0] payload_length;
		logic [7:0]  sequence_number;
	} result_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ HCRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ FCRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### rtl/crccfd_parser.sv
// Frame parser state machine for the CRC checked frame deframer.
// Consumes one byte per step and produces at most one result.
// Depends on crccfd_pkg.
`timescale 1ns / 1ps

module crccfd_parser
	import crccfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic [15:0] max_len,
	output logic        res_valid,
	output result_t     res
);

	parse_state_t st_q;
	parse_state_t st_nxt;
	logic [7:0]   hcrc_upd;
	logic [15:0]  fcrc_upd;
	logic [15:0]  pos_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= PH_HUNT;
			st_q.position      <= '0;
			st_q.length_seen   <= '0;
			st_q.command_seen  <= '0;
			st_q.sequence_seen <= '0;
			st_q.header_crc    <= HCRC_INIT;
			st_q.frame_crc     <= FCRC_INIT;
			st_q.crc_low       <= '0;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

	assign hcrc_upd = crc8_step(st_q.header_crc, byte_in);
	assign fcrc_upd = crc16_step(st_q.frame_crc, byte_in);
	assign pos_inc  = st_q.position + 16'd1;

	always_comb begin
		st_nxt    = st_q;
		res_valid = 1'b0;
		res       = '0;
		res.payload_length  = st_q.length_seen;
		res.sequence_number = st_q.sequence_seen;
		unique case (st_q.phase)
			PH_HEADER: begin
				st_nxt.frame_crc = fcrc_upd;
				if (st_q.position == 16'd4) begin
					st_nxt.phase    = PH_HUNT;
					st_nxt.position = '0;
					if (byte_in != st_q.header_crc) begin
						res_valid = 1'b1;
						res.kind  = KIND_HCRC_ERR;
					end else if (st_q.length_seen > max_len) begin
						res_valid = 1'b1;
						res.kind  = KIND_LENGTH_ERR;
					end else begin
						st_nxt.phase = PH_COMMAND;
					end
				end else begin
					if (st_q.position == 16'd1) begin
						st_nxt.length_seen = {st_q.length_seen[15:8], byte_in};
					end else if (st_q.position == 16'd2) begin
						st_nxt.length_seen = {byte_in, st_q.length_seen[7:0]};
					end else begin
						st_nxt.sequence_seen = byte_in;
					end
					st_nxt.header_crc = hcrc_upd;
					st_nxt.position   = pos_inc;
				end
			end
			PH_COMMAND: begin
				st_nxt.frame_crc = fcrc_upd;
				if (st_q.position == 16'd0) begin
					st_nxt.command_seen = {st_q.command_seen[15:8], byte_in};
					st_nxt.position     = 16'd1;
				end else begin
					st_nxt.command_seen = {byte_in, st_q.command_seen[7:0]};
					st_nxt.position     = '0;
					st_nxt.phase = (st_q.length_seen == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				st_nxt.frame_crc   = fcrc_upd;
				res_valid          = 1'b1;
				res.kind           = KIND_PAYLOAD;
				res.command_id     = st_q.command_seen;
				res.payload_offset = st_q.position;
				res.payload_byte   = byte_in;
				if (pos_inc == st_q.length_seen) begin
					st_nxt.position = '0;
					st_nxt.phase    = PH_TRAILER;
				end else begin
					st_nxt.position = pos_inc;
				end
			end
			PH_TRAILER: begin
				if (st_q.position == 16'd0) begin
					st_nxt.crc_low  = byte_in;
					st_nxt.position = 16'd1;
				end else begin
					st_nxt.position = '0;
					st_nxt.phase    = PH_HUNT;
					res_valid       = 1'b1;
					res.command_id  = st_q.command_seen;
					res.kind = ({byte_in, st_q.crc_low} == st_q.frame_crc) ?
						KIND_GOOD : KIND_FCRC_ERR;
				end
			end
			default: begin
				st_nxt.phase    = PH_HUNT;
				st_nxt.position = '0;
				if (byte_in == START_BYTE) begin
					st_nxt.header_crc = crc8_step(HCRC_INIT, byte_in);
					st_nxt.frame_crc  = crc16_step(FCRC_INIT, byte_in);
					st_nxt.phase      = PH_HEADER;
					st_nxt.position   = 16'd1;
				end
			end
		endcase
	end

endmodule

### rtl/crc_checked_frame_deframer_unit.sv
// A result reaches the outputs through the input register and then the result register.
// Throughput: one byte per cycle while the output does not stall; the input register feeds the
// parser, whose next state and CRC steps are combinational; the result register holds the output.
// The input stalls only while a result waits in the result register and the output stalls.
// Reset clears the parser to hunting and the length limit to 65535.
// Top level of the CRC checked frame deframer; depends on crccfd_pkg and crccfd_parser.
`timescale 1ns / 1ps

module crc_checked_frame_deframer_unit
	import crccfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [15:0] command_id,
	output logic [15:0] payload_offset,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_length,
	output logic [7:0]  sequence_number
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        step;
	logic        res_valid;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;
	logic [15:0] max_len_q;

	assign step     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	crccfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_q.kind;
	assign command_id      = out_q.command_id;
	assign payload_offset  = out_q.payload_offset;
	assign payload_byte    = out_q.payload_byte;
	assign payload_length  = out_q.payload_length;
	assign sequence_number = out_q.sequence_number;

endmodule
